[rtl/core/bbd_pkg.sv]
// bbd_pkg: shared types, constants and the site lookup for the Bayer demosaic unit.
// No dependencies; imported by bayer_bilinear_demosaic_unit.
`timescale 1ns / 1ps

package bbd_pkg;

	localparam int unsigned MAX_WIDTH_DEF = 4096;
	localparam int unsigned PIX_W         = 8;
	localparam int unsigned DIM_W         = 13;
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned DIM_MIN       = 4;
	localparam int unsigned HEIGHT_MAX    = 4096;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [DIM_W-1:0] dim_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN  = 2'd0,
		REG_RAW_ONLY = 2'd1,
		REG_WIDTH    = 2'd2,
		REG_HEIGHT   = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PAT_BGGR = 2'd0,
		PAT_GBRG = 2'd1,
		PAT_GRBG = 2'd2,
		PAT_RGGB = 2'd3
	} pattern_t;

	typedef enum logic [1:0] {
		SITE_R  = 2'd0,
		SITE_GR = 2'd1,
		SITE_GB = 2'd2,
		SITE_B  = 2'd3
	} site_t;

	// per-item control carried through the window stage
	typedef struct packed {
		logic emit;
		logic last;
		logic interior;
		logic x_odd;
		logic y_odd;
	} s1_ctl_t;

	// pos = {y odd, x odd}
	function automatic site_t site_lookup(input pattern_t pat, input logic [1:0] pos);
		site_t k;
		k = SITE_R;
		case (pat)
			PAT_BGGR: begin
				case (pos)
					2'd0: k = SITE_B;
					2'd1: k = SITE_GB;
					2'd2: k = SITE_GR;
					default: k = SITE_R;
				endcase
			end
			PAT_GBRG: begin
				case (pos)
					2'd0: k = SITE_GB;
					2'd1: k = SITE_B;
					2'd2: k = SITE_R;
					default: k = SITE_GR;
				endcase
			end
			PAT_GRBG: begin
				case (pos)
					2'd0: k = SITE_GR;
					2'd1: k = SITE_R;
					2'd2: k = SITE_B;
					default: k = SITE_GB;
				endcase
			end
			default: begin
				case (pos)
					2'd0: k = SITE_R;
					2'd1: k = SITE_GR;
					2'd2: k = SITE_GB;
					default: k = SITE_B;
				endcase
			end
		endcase
		return k;
	endfunction

endpackage

[rtl/core/bayer_bilinear_demosaic_unit.sv]
// Bilinear 3x3 Bayer demosaic, 8-bit raw in, RGB888 out, two line memories.
// Depends on bbd_pkg.
// Throughput: one beat per cycle in and out unless out_ready stalls; the result of pixel k
// leaves with input beat k+W+1 and reaches out_valid via the window and output registers.
// W+1 drain beats flush the tail of a frame.
// Reset: counters and valid flags clear, config to defaults; line memories and window do not.
`timescale 1ns / 1ps

module bayer_bilinear_demosaic_unit #(
	parameter int unsigned MAX_WIDTH = bbd_pkg::MAX_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  bbd_pkg::pix_t              raw_pixel,
	input  logic                       drain,
	output logic                       out_valid,
	input  logic                       out_ready,
	output bbd_pkg::pix_t              red,
	output bbd_pkg::pix_t              green,
	output bbd_pkg::pix_t              blue,
	output logic                       frame_end,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [bbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  bbd_pkg::dim_t              cfg_data
);
	import bbd_pkg::*;

	localparam int unsigned CW   = $clog2(MAX_WIDTH);
	localparam int unsigned EWW  = $clog2(MAX_WIDTH + 1);
	localparam int unsigned CMPW = (EWW > DIM_W) ? EWW : DIM_W;

	// config
	pattern_t pattern_q;
	logic     raw_only_q;
	dim_t     width_q;
	dim_t     height_q;

	logic [CMPW-1:0] eff_w;
	dim_t            eff_h;

	// raster position of the next beat
	logic [CW-1:0] col_q;
	dim_t          row_q;

	logic            in_acc;
	logic            tail;
	logic            drop;
	logic [CMPW-1:0] col_ext;
	logic [CMPW-1:0] col_inc;
	s1_ctl_t         ctl_in;
	logic            last_in;
	logic            cfg_size_wr;

	// window stage
	logic          s1_valid_q;
	s1_ctl_t       s1_ctl_s1;
	pix_t          s1_pix_s1;
	logic [CW-1:0] s1_addr_s1;
	pix_t          rd0_s1;
	pix_t          rd1_s1;
	logic          byp_s1;
	pix_t          byp0_s1;
	pix_t          byp1_s1;
	pix_t          win_q [9];
	pix_t          nw    [9];
	pix_t          col_mid;
	pix_t          col_top;
	logic          s1_leave;
	logic          s2_en;

	pix_t mem0 [MAX_WIDTH];
	pix_t mem1 [MAX_WIDTH];

	// output register
	logic out_valid_q;
	pix_t red_q;
	pix_t green_q;
	pix_t blue_q;
	logic frame_end_q;

	pix_t    r_c;
	pix_t    g_c;
	pix_t    b_c;
	logic [PIX_W:0]   hor_sum;
	logic [PIX_W:0]   ver_sum;
	logic [PIX_W+1:0] cross_sum;
	logic [PIX_W+1:0] diag_sum;
	pix_t    hor;
	pix_t    ver;
	pix_t    cross_v;
	pix_t    diag;
	site_t   kind;

	assign cfg_ready   = 1'b1;
	assign cfg_size_wr = cfg_valid && cfg_ready &&
		(cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

	always_comb begin
		if (width_q < DIM_W'(DIM_MIN))
			eff_w = CMPW'(DIM_MIN);
		else if (CMPW'(width_q) > CMPW'(MAX_WIDTH))
			eff_w = CMPW'(MAX_WIDTH);
		else
			eff_w = CMPW'(width_q);
		if (height_q < DIM_W'(DIM_MIN))
			eff_h = DIM_W'(DIM_MIN);
		else if (height_q > DIM_W'(HEIGHT_MAX))
			eff_h = DIM_W'(HEIGHT_MAX);
		else
			eff_h = height_q;
	end

	assign s2_en    = !out_valid_q || out_ready;
	assign s1_leave = s1_valid_q && s2_en;
	assign in_ready = !s1_valid_q || s2_en;
	assign in_acc   = in_valid && in_ready;

	assign tail    = row_q >= eff_h;
	assign drop    = !tail && drain;
	assign col_ext = CMPW'(col_q);
	assign col_inc = col_ext + CMPW'(1);
	assign last_in = (row_q == eff_h + DIM_W'(1)) && (col_q == '0);

	always_comb begin
		ctl_in.emit     = (row_q >= DIM_W'(2)) || (row_q == DIM_W'(1) && col_q != '0);
		ctl_in.last     = last_in;
		ctl_in.interior = (col_ext >= CMPW'(2)) && (row_q != DIM_W'(1)) && (row_q != eff_h);
		ctl_in.x_odd    = ~col_q[0];
		ctl_in.y_odd    = ~row_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q  <= PAT_BGGR;
			raw_only_q <= 1'b0;
			width_q    <= DIM_W'(640);
			height_q   <= DIM_W'(480);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_PATTERN:  pattern_q  <= pattern_t'(cfg_data[1:0]);
				REG_RAW_ONLY: raw_only_q <= cfg_data[0];
				REG_WIDTH:    width_q    <= cfg_data;
				REG_HEIGHT:   height_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_size_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc && !drop) begin
			if (last_in) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_inc == eff_w) begin
				col_q <= '0;
				row_q <= row_q + DIM_W'(1);
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (in_acc)
			s1_valid_q <= !drop;
		else if (s1_leave)
			s1_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_ctl_s1  <= ctl_in;
			s1_pix_s1  <= tail ? '0 : raw_pixel;
			s1_addr_s1 <= col_q;
			byp_s1     <= s1_leave && (s1_addr_s1 == col_q);
			byp0_s1    <= s1_pix_s1;
			byp1_s1    <= col_mid;
		end
	end

	// line memories: mem0 holds the latest line, mem1 the one before
	always_ff @(posedge clk) begin
		if (s1_leave)
			mem0[s1_addr_s1] <= s1_pix_s1;
		if (in_acc)
			rd0_s1 <= mem0[col_q];
	end

	always_ff @(posedge clk) begin
		if (s1_leave)
			mem1[s1_addr_s1] <= col_mid;
		if (in_acc)
			rd1_s1 <= mem1[col_q];
	end

	assign col_mid = byp_s1 ? byp0_s1 : rd0_s1;
	assign col_top = byp_s1 ? byp1_s1 : rd1_s1;

	always_comb begin
		nw[0] = win_q[1];
		nw[1] = win_q[2];
		nw[2] = col_top;
		nw[3] = win_q[4];
		nw[4] = win_q[5];
		nw[5] = col_mid;
		nw[6] = win_q[7];
		nw[7] = win_q[8];
		nw[8] = s1_pix_s1;
	end

	always_ff @(posedge clk) begin
		if (s1_leave)
			win_q <= nw;
	end

	assign hor_sum   = {1'b0, nw[3]} + {1'b0, nw[5]};
	assign ver_sum   = {1'b0, nw[1]} + {1'b0, nw[7]};
	assign cross_sum = {1'b0, hor_sum} + {1'b0, ver_sum};
	assign diag_sum  = {2'b00, nw[0]} + {2'b00, nw[2]} + {2'b00, nw[6]} + {2'b00, nw[8]};
	assign hor       = hor_sum[PIX_W:1];
	assign ver       = ver_sum[PIX_W:1];
	assign cross_v   = cross_sum[PIX_W+1:2];
	assign diag      = diag_sum[PIX_W+1:2];
	assign kind      = site_lookup(pattern_q, {s1_ctl_s1.y_odd, s1_ctl_s1.x_odd});

	always_comb begin
		r_c = '0;
		g_c = '0;
		b_c = '0;
		if (s1_ctl_s1.interior) begin
			case (kind)
				SITE_R: begin
					r_c = nw[4];
					g_c = raw_only_q ? '0 : cross_v;
					b_c = raw_only_q ? '0 : diag;
				end
				SITE_B: begin
					r_c = raw_only_q ? '0 : diag;
					g_c = raw_only_q ? '0 : cross_v;
					b_c = nw[4];
				end
				SITE_GR: begin
					r_c = raw_only_q ? '0 : hor;
					g_c = nw[4];
					b_c = raw_only_q ? '0 : ver;
				end
				default: begin
					r_c = raw_only_q ? '0 : ver;
					g_c = nw[4];
					b_c = raw_only_q ? '0 : hor;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s2_en)
			out_valid_q <= s1_valid_q && s1_ctl_s1.emit;
	end

	always_ff @(posedge clk) begin
		if (s2_en) begin
			red_q       <= r_c;
			green_q     <= g_c;
			blue_q      <= b_c;
			frame_end_q <= s1_ctl_s1.last;
		end
	end

	assign out_valid = out_valid_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;
	assign frame_end = frame_end_q;

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_ext < eff_w)
		else $error("column count out of range");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= eff_h + DIM_W'(1))
		else $error("row count out of range");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && s1_ctl_s1.last |-> s1_ctl_s1.emit)
		else $error("frame end on a beat without result");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !drop && last_in && !cfg_size_wr |=> col_q == '0 && row_q == '0)
		else $error("frame did not restart after last beat");

endmodule
